// File: hdl/kernel_image_signature_scanner_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the kernel image signature scanner
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KERNEL_IMAGE_SIGNATURE_SCANNER_DEFINES_SVH
`define KERNEL_IMAGE_SIGNATURE_SCANNER_DEFINES_SVH

`ifndef SYNTHESIS
// consequent must hold in the same cycle as the antecedent
`define KISS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// consequent must hold in the cycle after the antecedent
`define KISS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KISS_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define KISS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: hdl/kiss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kiss_pkg
// Constants, signature tables and shared types of the signature scanner.
// ----------------------------------------------------------------------------
package kiss_pkg;

    localparam int POS_BITS        = 32;
    localparam int OFS_BITS        = 32;
    localparam int HEADER_DISTANCE = 514;
    localparam int BOOT_SPAN       = HEADER_DISTANCE + 4;
    localparam int DELAY_DEPTH     = HEADER_DISTANCE - 11;
    localparam int DL_PTR_BITS     = $clog2(DELAY_DEPTH);
    localparam int HIST_DEPTH      = 16;
    localparam int EN_BITS         = 4;

    // start offsets relative to the completing byte
    localparam int A64_SPAN        = 59;
    localparam int ZIM_SPAN        = 3;
    localparam int ZIM_MIN_POS     = 39;
    localparam int BAN_SPAN        = 13;
    localparam int MAGIC_MIN_POS   = 15;

    // enable register bits
    localparam int EN_BOOT         = 0;
    localparam int EN_A64          = 1;
    localparam int EN_ZIM          = 2;
    localparam int EN_BAN          = 3;

    localparam int M_FIELD_BITS    = 4 * (OFS_BITS + 1);
    localparam int M_TDATA_BITS    = ((M_FIELD_BITS + 7) / 8) * 8;
    localparam int M_PAD_BITS      = M_TDATA_BITS - M_FIELD_BITS;

    localparam logic [7:0] BOOT_SIG [16] = '{
        8'hB8, 8'hC0, 8'h07, 8'h8E, 8'hD8, 8'hB8, 8'h00, 8'h90,
        8'h8E, 8'hC0, 8'hB9, 8'h00, 8'h01, 8'h29, 8'hF6, 8'h29
    };
    localparam logic [7:0] HDR_SIG [5]  = '{8'h21, 8'h48, 8'h64, 8'h72, 8'h53};
    localparam logic [7:0] A64_SIG [12] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h41, 8'h52, 8'h4D, 8'h64
    };
    localparam logic [7:0] ZLE_SIG [4]  = '{8'h18, 8'h28, 8'h6F, 8'h01};
    localparam logic [7:0] ZBE_SIG [4]  = '{8'h01, 8'h6F, 8'h28, 8'h18};
    localparam logic [7:0] BAN_SIG [14] = '{
        8'h4C, 8'h69, 8'h6E, 8'h75, 8'h78, 8'h20, 8'h76,
        8'h65, 8'h72, 8'h73, 8'h69, 8'h6F, 8'h6E, 8'h20
    };

    // one access of the magic delay line per accepted byte
    typedef struct packed {
        logic step;
        logic magic;
    } dl_req_t;

endpackage

// File: hdl/kiss_delay_line.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kiss_delay_line
// Circular one-bit RAM that delays boot magic matches by DELAY_DEPTH bytes.
// ----------------------------------------------------------------------------
`include "kernel_image_signature_scanner_defines.svh"

module kiss_delay_line
    import kiss_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  dl_req_t req,
    output logic    rd_bit
);

    logic                   mem [DELAY_DEPTH];
    logic [DL_PTR_BITS-1:0] ptr_reg;
    logic [DL_PTR_BITS-1:0] ptr_next;
    logic                   rd_bit_reg;

    localparam logic [DL_PTR_BITS-1:0] PTR_LAST = DL_PTR_BITS'(DELAY_DEPTH - 1);

    always_comb begin
        ptr_next = ptr_reg;
        if (req.step) begin
            ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + DL_PTR_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else begin
            ptr_reg <= ptr_next;
        end
    end

    // read-first: the old entry leaves as the new match goes in
    always_ff @(posedge aclk) begin
        if (req.step) begin
            rd_bit_reg   <= mem[ptr_reg];
            mem[ptr_reg] <= req.magic;
        end
    end

    assign rd_bit = rd_bit_reg;

    `KISS_ASSERT_SAME(a_ptr_range, aclk, aresetn, 1'b1, ptr_reg <= PTR_LAST)
    `KISS_ASSERT_NEXT(a_ptr_step, aclk, aresetn, req.step, ptr_reg == $past(ptr_next))
    `KISS_ASSERT_NEXT(a_idle_hold, aclk, aresetn, !req.step, $stable(ptr_reg))

endmodule

// File: hdl/kernel_image_signature_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kernel_image_signature_scanner
// Byte-stream scanner for four kernel image signatures.
// ----------------------------------------------------------------------------
// Usage:
//  - s_ channel: one blob byte per transaction in s_tdata, s_tlast marks
//    the final byte of a blob; position restarts at 0 after it.
//  - m_ channel: exactly one result transaction per input byte, in order,
//    carrying hit flags and start offsets of every signature ending there;
//    m_tlast copies the input last flag.
//  - cfg_ channel: writes the 4-bit signature enable, always ready; only
//    write while no byte is in flight.
//  - Pipeline: two register stages; a byte passes stage 1 and then the
//    output register, which drives m_tvalid for its result transaction.
//  - Throughput: 1 byte per cycle unless stalled. Each byte makes one RMW of
//    the magic delay RAM (one read-first access), which sets the rate.
//  - Reset: pipeline and position clear, enable returns to all ones. The
//    delay RAM is not swept; an entry only counts once 518 bytes of the
//    current blob have passed, by which time it has been written.
//  - Stall: with m_tready low the output register and stage 1 hold, the
//    RAM read is frozen, and s_tready drops once both are full.
// ----------------------------------------------------------------------------
`include "kernel_image_signature_scanner_defines.svh"

module kernel_image_signature_scanner
    import kiss_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // input stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // [7:0] data_byte
    input  logic                    s_tlast,   // last
    // result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [0] boot_hit, [32:1] boot_offset, [33] arm64_hit, [65:34] arm64_offset,
    // [66] zimage_hit, [98:67] zimage_offset, [99] banner_hit,
    // [131:100] banner_offset, [135:132] zero
    output logic [M_TDATA_BITS-1:0] m_tdata,
    output logic                    m_tlast,   // last_out
    // configuration: signature_enable
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [EN_BITS-1:0]      cfg_data
);

    // ---------------- control ----------------
    logic s_accept;
    logic out_load;
    logic s1_stall;

    logic               s1_valid_reg, s1_valid_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [EN_BITS-1:0] en_reg;

    assign out_load  = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || out_load;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign s1_stall  = s1_valid_reg && !out_load;

    // ---------------- window and position ----------------
    logic [7:0]          hist_reg [HIST_DEPTH-1];
    logic [7:0]          win [HIST_DEPTH];
    logic [POS_BITS-1:0] pos_reg, pos_next;

    always_comb begin
        win[0] = s_tdata;
        for (int k = 1; k < HIST_DEPTH; k++) begin
            win[k] = hist_reg[k-1];
        end
    end

    assign pos_next = s_tlast ? '0 : pos_reg + POS_BITS'(1);

    // pattern[i] sits len-1-i bytes back from the newest byte
    logic m_boot, m_hdr, m_a64, m_zle, m_zbe, m_ban;

    always_comb begin
        m_boot = 1'b1;
        m_hdr  = 1'b1;
        m_a64  = 1'b1;
        m_zle  = 1'b1;
        m_zbe  = 1'b1;
        m_ban  = 1'b1;
        for (int i = 0; i < 16; i++) begin
            if (win[15-i] != BOOT_SIG[i]) m_boot = 1'b0;
        end
        for (int i = 0; i < 5; i++) begin
            if (win[4-i] != HDR_SIG[i]) m_hdr = 1'b0;
        end
        for (int i = 0; i < 12; i++) begin
            if (win[11-i] != A64_SIG[i]) m_a64 = 1'b0;
        end
        for (int i = 0; i < 4; i++) begin
            if (win[3-i] != ZLE_SIG[i]) m_zle = 1'b0;
            if (win[3-i] != ZBE_SIG[i]) m_zbe = 1'b0;
        end
        for (int i = 0; i < 14; i++) begin
            if (win[13-i] != BAN_SIG[i]) m_ban = 1'b0;
        end
    end

    // magic match goes into the delay RAM, 503 bytes back comes out
    dl_req_t dl_req;
    logic    dl_rd_bit;

    assign dl_req.step  = s_accept;
    assign dl_req.magic = (pos_reg >= POS_BITS'(MAGIC_MIN_POS)) && m_boot;

    kiss_delay_line u_delay (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dl_req),
        .rd_bit  (dl_rd_bit)
    );

    // ---------------- stage 1: flags, aligned with RAM read data ----------------
    logic [POS_BITS-1:0] s1_pos_reg;
    logic                s1_last_reg;
    logic                s1_boot_ok_reg;
    logic                s1_a64_reg;
    logic                s1_zim_reg;
    logic                s1_ban_reg;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (out_load) begin
            s1_valid_next = 1'b0;
        end
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            pos_reg      <= '0;
            en_reg       <= {EN_BITS{1'b1}};
            for (int k = 0; k < HIST_DEPTH - 1; k++) begin
                hist_reg[k] <= '0;
            end
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid) begin
                en_reg <= cfg_data;
            end
            if (s_accept) begin
                pos_reg     <= pos_next;
                hist_reg[0] <= s_tdata;
                for (int k = 1; k < HIST_DEPTH - 1; k++) begin
                    hist_reg[k] <= hist_reg[k-1];
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pos_reg     <= pos_reg;
            s1_last_reg    <= s_tlast;
            s1_boot_ok_reg <= en_reg[EN_BOOT] && m_hdr
                              && (pos_reg >= POS_BITS'(BOOT_SPAN));
            s1_a64_reg     <= en_reg[EN_A64] && m_a64
                              && (pos_reg >= POS_BITS'(A64_SPAN));
            s1_zim_reg     <= en_reg[EN_ZIM] && (m_zle || m_zbe)
                              && (pos_reg >= POS_BITS'(ZIM_MIN_POS));
            s1_ban_reg     <= en_reg[EN_BAN] && m_ban
                              && (pos_reg >= POS_BITS'(BAN_SPAN));
        end
    end

    // ---------------- stage 2: offsets into the output register ----------------
    logic                    boot_hit;
    logic [OFS_BITS-1:0]     boot_ofs, a64_ofs, zim_ofs, ban_ofs;
    logic [M_TDATA_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic                    m_tlast_reg;

    assign boot_hit = s1_boot_ok_reg && dl_rd_bit;

    always_comb begin
        boot_ofs = boot_hit ? OFS_BITS'(s1_pos_reg - POS_BITS'(BOOT_SPAN)) : '0;
        a64_ofs  = s1_a64_reg ? OFS_BITS'(s1_pos_reg - POS_BITS'(A64_SPAN)) : '0;
        zim_ofs  = s1_zim_reg ? OFS_BITS'(s1_pos_reg - POS_BITS'(ZIM_SPAN)) : '0;
        ban_ofs  = s1_ban_reg ? OFS_BITS'(s1_pos_reg - POS_BITS'(BAN_SPAN)) : '0;
        m_tdata_next = {M_PAD_BITS'(0),
                        ban_ofs, s1_ban_reg,
                        zim_ofs, s1_zim_reg,
                        a64_ofs, s1_a64_reg,
                        boot_ofs, boot_hit};
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------- checks ----------------
    `KISS_ASSERT_SAME(a_accept_room, aclk, aresetn, s_accept, !s1_valid_reg || out_load)
    `KISS_ASSERT_NEXT(a_pos_restart, aclk, aresetn, s_accept && s_tlast, pos_reg == '0)
    `KISS_ASSERT_NEXT(a_s1_hold, aclk, aresetn, s1_stall, s1_valid_reg && $stable(s1_pos_reg))
    `KISS_ASSERT_SAME(a_boot_miss_zero, aclk, aresetn, !boot_hit, boot_ofs == '0)

endmodule
